// File: src/kcv_pkg.sv
// ----------------------------------------------------------------------------
// kcv_pkg: shared types and constants
// Codes, widths and the job descriptor of the constant-velocity filter core.
// ----------------------------------------------------------------------------
package kcv_pkg;

  localparam int DW      = 32;
  localparam int WW      = 64;
  localparam int CFG_W   = 31;
  localparam int STAMP_W = 48;
  localparam int PAW     = 5;

  localparam logic [STAMP_W-1:0] DT_MIN    = 48'd66;
  localparam logic [STAMP_W-1:0] DT_MAX    = 48'h0000_7FFF_FFFF;
  localparam logic signed [WW-1:0] DET_FLOOR = 64'sd281;

  localparam logic signed [DW-1:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [WW-1:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WW-1:0] MIN64 = 64'sh8000_0000_0000_0000;

  // B-side operand classes
  localparam logic [2:0] BC_ZERO = 3'd0;
  localparam logic [2:0] BC_EST  = 3'd1;
  localparam logic [2:0] BC_COV  = 3'd2;
  localparam logic [2:0] BC_Y    = 3'd3;
  localparam logic [2:0] BC_H    = 3'd4;
  localparam logic [2:0] BC_S11  = 3'd5;
  localparam logic [2:0] BC_S10  = 3'd6;

  // A-side operand classes
  localparam logic [2:0] AC_DT  = 3'd0;
  localparam logic [2:0] AC_K   = 3'd1;
  localparam logic [2:0] AC_S00 = 3'd2;
  localparam logic [2:0] AC_S01 = 3'd3;
  localparam logic [2:0] AC_S10 = 3'd4;
  localparam logic [2:0] AC_S11 = 3'd5;

  // add-in terms
  localparam logic [2:0] AI_NONE = 3'd0;
  localparam logic [2:0] AI_MXX  = 3'd1;
  localparam logic [2:0] AI_MXY  = 3'd2;
  localparam logic [2:0] AI_MYX  = 3'd3;
  localparam logic [2:0] AI_MYY  = 3'd4;
  localparam logic [2:0] AI_PX   = 3'd5;
  localparam logic [2:0] AI_PY   = 3'd6;
  localparam logic [2:0] AI_Q    = 3'd7;

  // destinations
  localparam logic [2:0] D_EST = 3'd0;
  localparam logic [2:0] D_COV = 3'd1;
  localparam logic [2:0] D_S   = 3'd2;
  localparam logic [2:0] D_Y   = 3'd3;
  localparam logic [2:0] D_DET = 3'd4;
  localparam logic [2:0] D_NUM = 3'd5;

  // product scaling
  localparam logic [1:0] SH_RAW = 2'd0;
  localparam logic [1:0] SH_16  = 2'd1;
  localparam logic [1:0] SH_24  = 2'd2;

  localparam logic [5:0] LAST_PRED = 6'd21;
  localparam logic [5:0] LAST_MEAS = 6'd34;

  typedef struct packed {
    logic [2:0] base_c;
    logic [3:0] base_i;
    logic       base_neg;
    logic [2:0] add_c;
    logic [1:0] add_i;
    logic [1:0] nterm;
    logic [2:0] a1_c;
    logic [2:0] a1_i;
    logic [2:0] b1_c;
    logic [3:0] b1_i;
    logic       n1;
    logic [2:0] a2_c;
    logic [2:0] a2_i;
    logic [2:0] b2_c;
    logic [3:0] b2_i;
    logic       n2;
    logic [1:0] sh;
    logic [2:0] dst_c;
    logic [3:0] dst_i;
  } job_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  function automatic logic [CFG_W-1:0] cfg_reset(input logic [2:0] idx);
    logic [CFG_W-1:0] v;
    case (idx)
      3'd0:    v = 31'd167772;
      3'd1:    v = 31'd335544;
      3'd2:    v = 31'd167772;
      3'd3:    v = 31'd167772;
      3'd4:    v = 31'd3355443;
      3'd5:    v = 31'd1342177;
      3'd6:    v = 31'd838861;
      default: v = 31'd838861;
    endcase
    return v;
  endfunction

endpackage

// File: src/kcv_div.sv
// ----------------------------------------------------------------------------
// kcv_div: gain divider
// Bit-serial signed divide giving round(n * 2^24 / d), saturated to 32 bits.
// ----------------------------------------------------------------------------
module kcv_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [kcv_pkg::WW-1:0]   num,
  input  logic signed [kcv_pkg::WW-1:0]   den,
  output logic signed [kcv_pkg::DW-1:0]   quo,
  output kcv_pkg::div_stat_t              stat
);

  logic                       busy;
  logic                       done;
  logic                       sat;
  logic                       neg;
  logic [4:0]                 cnt;
  logic [kcv_pkg::WW-1:0]     rem;
  logic [kcv_pkg::WW-1:0]     dvs;
  logic [kcv_pkg::DW-1:0]     shreg;
  logic [kcv_pkg::DW-1:0]     q;

  logic [kcv_pkg::WW-1:0]     un;
  logic [kcv_pkg::WW-1:0]     ud;
  logic                       over;
  logic [kcv_pkg::WW:0]       r2;
  logic                       ge;
  logic [kcv_pkg::WW:0]       r2_sub;
  logic [kcv_pkg::DW-1:0]     qf;
  logic [kcv_pkg::DW:0]       qinc;
  logic [kcv_pkg::DW-1:0]     rq;

  always_comb begin
    un     = num[kcv_pkg::WW-1] ? (64'd0 - num) : num;
    ud     = den[kcv_pkg::WW-1] ? (64'd0 - den) : den;
    over   = ({7'd0, un} >= {ud, 7'd0});
    r2     = {rem, shreg[kcv_pkg::DW-1]};
    ge     = (r2 >= {1'b0, dvs});
    r2_sub = r2 - {1'b0, dvs};
    qf     = {q[kcv_pkg::DW-2:0], ge};
    qinc   = {1'b0, qf} + 33'd1;
    rq     = qinc[kcv_pkg::DW:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[kcv_pkg::WW-1] ^ den[kcv_pkg::WW-1];
        if (over) begin
          quo  <= (num[kcv_pkg::WW-1] ^ den[kcv_pkg::WW-1]) ? kcv_pkg::MIN32 : kcv_pkg::MAX32;
          sat  <= 1'b1;
          done <= 1'b1;
        end else begin
          rem   <= {7'd0, un[kcv_pkg::WW-1:7]};
          shreg <= {un[6:0], 25'd0};
          dvs   <= ud;
          q     <= '0;
          cnt   <= '0;
          sat   <= 1'b0;
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= ge ? r2_sub[kcv_pkg::WW-1:0] : r2[kcv_pkg::WW-1:0];
        shreg <= {shreg[kcv_pkg::DW-2:0], 1'b0};
        q     <= qf;
        cnt   <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            quo <= $signed(32'd0 - rq);
            sat <= 1'b0;
          end else if (rq[kcv_pkg::DW-1]) begin
            quo <= kcv_pkg::MAX32;
            sat <= 1'b1;
          end else begin
            quo <= $signed(rq);
            sat <= 1'b0;
          end
        end
      end
    end
  end

  assign stat = '{done: done, sat: sat};

endmodule

// File: src/kalman_filter_cv2d_position_core.sv
// ----------------------------------------------------------------------------
// kalman_filter_cv2d_position_core: constant-velocity 2D Kalman filter
// Predict and position-update steps run as jobs on one shared 32x32
// multiplier and accumulator, with a bit-serial divider for the gain.
// In a measurement update the eight gain divisions dominate the run time.
// One item at a time; the result register frees the input side at once.
// Synchronous reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
module kalman_filter_cv2d_position_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kcv_pkg::PAW-1:0]             paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                cmd,
  input  logic [kcv_pkg::STAMP_W-1:0]         stamp,
  input  logic signed [kcv_pkg::DW-1:0]       pos_x,
  input  logic signed [kcv_pkg::DW-1:0]       pos_y,
  input  logic signed [kcv_pkg::DW-1:0]       vel_x,
  input  logic signed [kcv_pkg::DW-1:0]       vel_y,
  input  logic signed [kcv_pkg::DW-1:0]       meas_cov_xx,
  input  logic signed [kcv_pkg::DW-1:0]       meas_cov_xy,
  input  logic signed [kcv_pkg::DW-1:0]       meas_cov_yx,
  input  logic signed [kcv_pkg::DW-1:0]       meas_cov_yy,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [kcv_pkg::DW-1:0]       est_x,
  output logic signed [kcv_pkg::DW-1:0]       est_y,
  output logic signed [kcv_pkg::DW-1:0]       est_vx,
  output logic signed [kcv_pkg::DW-1:0]       est_vy,
  output logic signed [kcv_pkg::DW-1:0]       var_x,
  output logic signed [kcv_pkg::DW-1:0]       covar_xy,
  output logic signed [kcv_pkg::DW-1:0]       var_y,
  output logic                                saturated
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DT   = 4'd1;
  localparam logic [3:0] ST_LD   = 4'd2;
  localparam logic [3:0] ST_MUL1 = 4'd3;
  localparam logic [3:0] ST_ACC1 = 4'd4;
  localparam logic [3:0] ST_MUL2 = 4'd5;
  localparam logic [3:0] ST_ACC2 = 4'd6;
  localparam logic [3:0] ST_WR   = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_DWT  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  function automatic kcv_pkg::job_t job_of(input logic meas, input logic [5:0] j);
    kcv_pkg::job_t r;
    logic [5:0]    m;
    r = '0;
    m = '0;
    if (!meas) begin
      if (j < 6'd2) begin
        r.base_c = kcv_pkg::BC_EST;
        r.base_i = {3'd0, j[0]};
        r.nterm  = 2'd1;
        r.a1_c   = kcv_pkg::AC_DT;
        r.b1_c   = kcv_pkg::BC_EST;
        r.b1_i   = {3'b001, j[0]};
        r.sh     = kcv_pkg::SH_16;
        r.dst_c  = kcv_pkg::D_EST;
        r.dst_i  = {3'd0, j[0]};
      end else if (j < 6'd10) begin
        m        = j - 6'd2;
        r.base_c = kcv_pkg::BC_COV;
        r.base_i = {1'b0, m[2:0]};
        r.nterm  = 2'd1;
        r.a1_c   = kcv_pkg::AC_DT;
        r.b1_c   = kcv_pkg::BC_COV;
        r.b1_i   = {1'b1, m[2:0]};
        r.sh     = kcv_pkg::SH_16;
        r.dst_c  = kcv_pkg::D_COV;
        r.dst_i  = {1'b0, m[2:0]};
      end else if (j < 6'd18) begin
        m        = j - 6'd10;
        r.base_c = kcv_pkg::BC_COV;
        r.base_i = {m[2:1], 1'b0, m[0]};
        r.nterm  = 2'd1;
        r.a1_c   = kcv_pkg::AC_DT;
        r.b1_c   = kcv_pkg::BC_COV;
        r.b1_i   = {m[2:1], 1'b1, m[0]};
        r.sh     = kcv_pkg::SH_16;
        r.dst_c  = kcv_pkg::D_COV;
        r.dst_i  = {m[2:1], 1'b0, m[0]};
      end else begin
        m        = j - 6'd18;
        r.base_c = kcv_pkg::BC_COV;
        r.base_i = {m[1:0], m[1:0]};
        r.add_c  = kcv_pkg::AI_Q;
        r.add_i  = m[1:0];
        r.dst_c  = kcv_pkg::D_COV;
        r.dst_i  = {m[1:0], m[1:0]};
      end
    end else begin
      if (j < 6'd4) begin
        r.base_c = kcv_pkg::BC_COV;
        r.base_i = {1'b0, j[1], 1'b0, j[0]};
        case (j[1:0])
          2'd0:    r.add_c = kcv_pkg::AI_MXX;
          2'd1:    r.add_c = kcv_pkg::AI_MXY;
          2'd2:    r.add_c = kcv_pkg::AI_MYX;
          default: r.add_c = kcv_pkg::AI_MYY;
        endcase
        r.dst_c  = kcv_pkg::D_S;
        r.dst_i  = {2'd0, j[1:0]};
      end else if (j < 6'd6) begin
        r.base_c   = kcv_pkg::BC_EST;
        r.base_i   = {3'd0, j[0]};
        r.base_neg = 1'b1;
        r.add_c    = j[0] ? kcv_pkg::AI_PY : kcv_pkg::AI_PX;
        r.dst_c    = kcv_pkg::D_Y;
        r.dst_i    = {3'd0, j[0]};
      end else if (j == 6'd6) begin
        r.nterm = 2'd2;
        r.a1_c  = kcv_pkg::AC_S00;
        r.b1_c  = kcv_pkg::BC_S11;
        r.a2_c  = kcv_pkg::AC_S01;
        r.b2_c  = kcv_pkg::BC_S10;
        r.n2    = 1'b1;
        r.dst_c = kcv_pkg::D_DET;
      end else if (j < 6'd15) begin
        m       = j - 6'd7;
        r.nterm = 2'd2;
        r.b1_c  = kcv_pkg::BC_COV;
        r.b2_c  = kcv_pkg::BC_COV;
        r.n2    = 1'b1;
        if (!m[0]) begin
          r.a1_c = kcv_pkg::AC_S11;
          r.b1_i = {m[2:1], 2'b00};
          r.a2_c = kcv_pkg::AC_S10;
          r.b2_i = {m[2:1], 2'b01};
        end else begin
          r.a1_c = kcv_pkg::AC_S00;
          r.b1_i = {m[2:1], 2'b01};
          r.a2_c = kcv_pkg::AC_S01;
          r.b2_i = {m[2:1], 2'b00};
        end
        r.dst_c = kcv_pkg::D_NUM;
        r.dst_i = {1'b0, m[2:0]};
      end else if (j < 6'd19) begin
        m        = j - 6'd15;
        r.base_c = kcv_pkg::BC_EST;
        r.base_i = {2'd0, m[1:0]};
        r.nterm  = 2'd2;
        r.a1_c   = kcv_pkg::AC_K;
        r.a1_i   = {m[1:0], 1'b0};
        r.b1_c   = kcv_pkg::BC_Y;
        r.b1_i   = 4'd0;
        r.a2_c   = kcv_pkg::AC_K;
        r.a2_i   = {m[1:0], 1'b1};
        r.b2_c   = kcv_pkg::BC_Y;
        r.b2_i   = 4'd1;
        r.sh     = kcv_pkg::SH_24;
        r.dst_c  = kcv_pkg::D_EST;
        r.dst_i  = {2'd0, m[1:0]};
      end else begin
        m        = j - 6'd19;
        r.base_c = kcv_pkg::BC_COV;
        r.base_i = m[3:0];
        r.nterm  = 2'd2;
        r.a1_c   = kcv_pkg::AC_K;
        r.a1_i   = {m[3:2], 1'b0};
        r.b1_c   = kcv_pkg::BC_H;
        r.b1_i   = {2'b00, m[1:0]};
        r.n1     = 1'b1;
        r.a2_c   = kcv_pkg::AC_K;
        r.a2_i   = {m[3:2], 1'b1};
        r.b2_c   = kcv_pkg::BC_H;
        r.b2_i   = {2'b01, m[1:0]};
        r.n2     = 1'b1;
        r.sh     = kcv_pkg::SH_24;
        r.dst_c  = kcv_pkg::D_COV;
        r.dst_i  = m[3:0];
      end
    end
    return r;
  endfunction

  logic [kcv_pkg::CFG_W-1:0]      cfg [8];

  logic [3:0]                     step;
  logic [5:0]                     job;
  logic                           is_meas;
  logic                           init_done;
  logic                           satf;
  logic signed [kcv_pkg::DW-1:0]  est [4];
  logic signed [kcv_pkg::DW-1:0]  cov [16];
  logic signed [kcv_pkg::DW-1:0]  k [8];
  logic signed [kcv_pkg::DW-1:0]  h [8];
  logic signed [kcv_pkg::DW-1:0]  y [2];
  logic signed [kcv_pkg::DW-1:0]  s00, s01, s10, s11;
  logic [kcv_pkg::CFG_W-1:0]      dt;
  logic [kcv_pkg::STAMP_W-1:0]    last_stamp;
  logic [kcv_pkg::STAMP_W-1:0]    stamp_q;
  logic signed [kcv_pkg::DW-1:0]  px_q, py_q, mxx_q, mxy_q, myx_q, myy_q;
  logic signed [kcv_pkg::WW-1:0]  det;
  logic signed [kcv_pkg::WW-1:0]  num;
  logic signed [65:0]             acc;
  logic signed [kcv_pkg::WW-1:0]  prod;

  kcv_pkg::job_t                  jb;
  logic [2:0]                     a_c;
  logic [2:0]                     a_i;
  logic [2:0]                     b_c;
  logic [3:0]                     b_i;
  logic signed [kcv_pkg::DW-1:0]  aval;
  logic signed [kcv_pkg::DW-1:0]  bval;
  logic signed [32:0]             addv;
  logic signed [32:0]             b33;
  logic signed [65:0]             ld_val;
  logic signed [64:0]             prod65;
  logic signed [64:0]             term;
  logic                           tneg;
  logic signed [65:0]             acc_step;
  logic                           fits32;
  logic                           fits64;
  logic signed [kcv_pkg::DW-1:0]  sat32v;
  logic signed [kcv_pkg::WW-1:0]  sat64v;
  logic signed [kcv_pkg::WW-1:0]  det_in;
  logic [kcv_pkg::STAMP_W-1:0]    diff;
  logic [kcv_pkg::CFG_W-1:0]      dt_val;
  logic                           dt_clamp;
  logic [5:0]                     last_job;
  logic                           accept;
  logic signed [kcv_pkg::DW-1:0]  div_q;
  kcv_pkg::div_stat_t             div_st;

  assign pready = 1'b1;
  assign prdata = {1'b0, cfg[paddr[4:2]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        cfg[i] <= kcv_pkg::cfg_reset(3'(i));
      end
    end else if (psel && penable && pwrite) begin
      cfg[paddr[4:2]] <= pwdata[kcv_pkg::CFG_W-1:0];
    end
  end

  assign jb         = job_of(is_meas, job);
  assign item_stall = (step != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign last_job   = is_meas ? kcv_pkg::LAST_MEAS : kcv_pkg::LAST_PRED;

  always_comb begin
    case (step)
      ST_MUL1: begin
        a_c = jb.a1_c; a_i = jb.a1_i; b_c = jb.b1_c; b_i = jb.b1_i;
      end
      ST_MUL2: begin
        a_c = jb.a2_c; a_i = jb.a2_i; b_c = jb.b2_c; b_i = jb.b2_i;
      end
      default: begin
        a_c = jb.a1_c; a_i = jb.a1_i; b_c = jb.base_c; b_i = jb.base_i;
      end
    endcase

    case (a_c)
      kcv_pkg::AC_DT:  aval = $signed({1'b0, dt});
      kcv_pkg::AC_K:   aval = k[a_i];
      kcv_pkg::AC_S00: aval = s00;
      kcv_pkg::AC_S01: aval = s01;
      kcv_pkg::AC_S10: aval = s10;
      kcv_pkg::AC_S11: aval = s11;
      default:         aval = '0;
    endcase

    case (b_c)
      kcv_pkg::BC_EST: bval = est[b_i[1:0]];
      kcv_pkg::BC_COV: bval = cov[b_i];
      kcv_pkg::BC_Y:   bval = y[b_i[0]];
      kcv_pkg::BC_H:   bval = h[b_i[2:0]];
      kcv_pkg::BC_S11: bval = s11;
      kcv_pkg::BC_S10: bval = s10;
      default:         bval = '0;
    endcase

    case (jb.add_c)
      kcv_pkg::AI_MXX: addv = {mxx_q[31], mxx_q};
      kcv_pkg::AI_MXY: addv = {mxy_q[31], mxy_q};
      kcv_pkg::AI_MYX: addv = {myx_q[31], myx_q};
      kcv_pkg::AI_MYY: addv = {myy_q[31], myy_q};
      kcv_pkg::AI_PX:  addv = {px_q[31], px_q};
      kcv_pkg::AI_PY:  addv = {py_q[31], py_q};
      kcv_pkg::AI_Q:   addv = $signed({2'b00, cfg[{1'b0, jb.add_i}]});
      default:         addv = '0;
    endcase

    b33    = jb.base_neg ? -$signed({bval[31], bval}) : $signed({bval[31], bval});
    ld_val = $signed({{33{b33[32]}}, b33}) + $signed({{33{addv[32]}}, addv});

    prod65 = $signed({prod[63], prod});
    case (jb.sh)
      kcv_pkg::SH_16: term = (prod65 + 65'sd32768) >>> 16;
      kcv_pkg::SH_24: term = (prod65 + 65'sd8388608) >>> 24;
      default:        term = prod65;
    endcase
    tneg     = (step == ST_ACC2) ? jb.n2 : jb.n1;
    acc_step = tneg ? acc - $signed({term[64], term}) : acc + $signed({term[64], term});

    fits32 = (acc[65:31] == {35{acc[31]}});
    sat32v = fits32 ? acc[31:0] : (acc[65] ? kcv_pkg::MIN32 : kcv_pkg::MAX32);
    fits64 = (acc[65:63] == 3'b000) || (acc[65:63] == 3'b111);
    sat64v = fits64 ? acc[63:0] : (acc[65] ? kcv_pkg::MIN64 : kcv_pkg::MAX64);
    det_in = (sat64v > -kcv_pkg::DET_FLOOR && sat64v < kcv_pkg::DET_FLOOR) ?
             kcv_pkg::DET_FLOOR : sat64v;

    diff     = (stamp_q > last_stamp) ? (stamp_q - last_stamp) : '0;
    dt_clamp = 1'b0;
    if (diff < kcv_pkg::DT_MIN) begin
      dt_val = kcv_pkg::DT_MIN[kcv_pkg::CFG_W-1:0];
    end else if (diff > kcv_pkg::DT_MAX) begin
      dt_val   = kcv_pkg::DT_MAX[kcv_pkg::CFG_W-1:0];
      dt_clamp = 1'b1;
    end else begin
      dt_val = diff[kcv_pkg::CFG_W-1:0];
    end
  end

  kcv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (step == ST_DIV),
    .num   (num),
    .den   (det),
    .quo   (div_q),
    .stat  (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      init_done    <= 1'b0;
      result_valid <= 1'b0;
      job          <= '0;
      is_meas      <= 1'b0;
      satf         <= 1'b0;
    end else begin
      prod <= aval * bval;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (step)
        ST_IDLE: begin
          if (accept) begin
            stamp_q <= stamp;
            px_q    <= pos_x;
            py_q    <= pos_y;
            mxx_q   <= meas_cov_xx;
            mxy_q   <= meas_cov_xy;
            myx_q   <= meas_cov_yx;
            myy_q   <= meas_cov_yy;
            satf    <= 1'b0;
            is_meas <= cmd;
            job     <= '0;
            for (int i = 0; i < 8; i++) begin
              h[i] <= cov[i];
            end
            if (!cmd && !init_done) begin
              est[0] <= pos_x;
              est[1] <= pos_y;
              est[2] <= vel_x;
              est[3] <= vel_y;
              for (int i = 0; i < 16; i++) begin
                cov[i] <= '0;
              end
              cov[0]     <= $signed({1'b0, cfg[4]});
              cov[5]     <= $signed({1'b0, cfg[5]});
              cov[10]    <= $signed({1'b0, cfg[6]});
              cov[15]    <= $signed({1'b0, cfg[7]});
              last_stamp <= stamp;
              init_done  <= 1'b1;
              step       <= ST_OUT;
            end else if (!cmd) begin
              step <= ST_DT;
            end else if (init_done) begin
              step <= ST_LD;
            end
          end
        end
        ST_DT: begin
          dt         <= dt_val;
          last_stamp <= stamp_q;
          satf       <= satf | dt_clamp;
          step       <= ST_LD;
        end
        ST_LD: begin
          acc  <= ld_val;
          step <= (jb.nterm == 2'd0) ? ST_WR : ST_MUL1;
        end
        ST_MUL1: begin
          step <= ST_ACC1;
        end
        ST_ACC1: begin
          acc  <= acc_step;
          step <= (jb.nterm == 2'd2) ? ST_MUL2 : ST_WR;
        end
        ST_MUL2: begin
          step <= ST_ACC2;
        end
        ST_ACC2: begin
          acc  <= acc_step;
          step <= ST_WR;
        end
        ST_WR: begin
          case (jb.dst_c)
            kcv_pkg::D_EST: begin
              est[jb.dst_i[1:0]] <= sat32v;
              satf <= satf | !fits32;
            end
            kcv_pkg::D_COV: begin
              cov[jb.dst_i] <= sat32v;
              satf <= satf | !fits32;
            end
            kcv_pkg::D_S: begin
              case (jb.dst_i[1:0])
                2'd0:    s00 <= sat32v;
                2'd1:    s01 <= sat32v;
                2'd2:    s10 <= sat32v;
                default: s11 <= sat32v;
              endcase
              satf <= satf | !fits32;
            end
            kcv_pkg::D_Y: begin
              y[jb.dst_i[0]] <= sat32v;
              satf <= satf | !fits32;
            end
            kcv_pkg::D_DET: begin
              det  <= det_in;
              satf <= satf | !fits64;
            end
            default: begin
              num  <= sat64v;
              satf <= satf | !fits64;
            end
          endcase
          if (jb.dst_c == kcv_pkg::D_NUM) begin
            step <= ST_DIV;
          end else if (job == last_job) begin
            step <= ST_OUT;
          end else begin
            job  <= job + 6'd1;
            step <= ST_LD;
          end
        end
        ST_DIV: begin
          step <= ST_DWT;
        end
        ST_DWT: begin
          if (div_st.done) begin
            k[jb.dst_i[2:0]] <= div_q;
            satf <= satf | div_st.sat;
            if (job == last_job) begin
              step <= ST_OUT;
            end else begin
              job  <= job + 6'd1;
              step <= ST_LD;
            end
          end
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            est_x        <= est[0];
            est_y        <= est[1];
            est_vx       <= est[2];
            est_vy       <= est[3];
            var_x        <= cov[0];
            covar_xy     <= cov[1];
            var_y        <= cov[5];
            saturated    <= satf;
            result_valid <= 1'b1;
            step         <= ST_IDLE;
          end
        end
        default: begin
          step <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
